// File: hdl/tspes_pkg.sv
// shared types and constants for the transport stream pes parser
`default_nettype none
package tspes_pkg;

    localparam int TS_PACKET_BYTES = 188;
    localparam int PES_COUNT_BITS = 24;
    localparam int HDR_BYTES = 19;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] SYNC_BYTE = 8'h47;
    localparam logic [7:0] AUDIO_ID = 8'hBD;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_RECORD = 2'd1,
        KIND_TS_ERR = 2'd2
    } kind_t;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_SHORT       = 4'd1;
    localparam logic [3:0] ST_STREAM_ID   = 4'd2;
    localparam logic [3:0] ST_START_CODE  = 4'd3;
    localparam logic [3:0] ST_HDR_LEN     = 4'd4;
    localparam logic [3:0] ST_NO_PTS      = 4'd5;
    localparam logic [3:0] ST_BAD_FLAGS   = 4'd6;
    localparam logic [3:0] ST_DTS_PREFIX  = 4'd7;
    localparam logic [3:0] ST_MARKER      = 4'd8;
    localparam logic [3:0] ST_PTS_PREFIX  = 4'd9;
    localparam logic [3:0] ST_EMPTY       = 4'd10;
    localparam logic [3:0] ST_DECL_LEN    = 4'd11;
    localparam logic [3:0] ST_SYNC        = 4'd12;
    localparam logic [3:0] ST_AFC         = 4'd13;
    localparam logic [3:0] ST_OFFSET      = 4'd14;

    typedef struct packed {
        logic        has_rec;
        kind_t       rec_kind;
        logic [3:0]  status;
        logic [32:0] pts;
        logic [32:0] dts;
        logic [8:0]  payload_begin;
        logic [23:0] payload_finish;
        logic [15:0] declared_length;
        logic        has_fwd;
        logic [7:0]  pes_byte;
        logic [23:0] byte_index;
    } event_t;

endpackage
`default_nettype wire

// File: hdl/ts_pid_filter_pes_header_parser_core.sv
// top level of the transport stream pid filter and pes header parser
//
// input side: one transport stream byte per word on ts_byte, taken when
// push is high and full is low; the first byte after reset starts a packet
// result side: the oldest result sits on the ports while empty is low and
// leaves when pop is high; last marks the final result of one byte
// each byte yields zero, one or two results; two only on the fifth byte
// of a packet (a record, then the first payload byte)
// a result is written into the event queue when its byte is taken
// one byte per cycle while results are drained; a byte giving
// two results holds its queue slot until both of them are popped
// a four-entry event queue separates parser and output; when the receiver
// stalls the queue fills and full rises, no result is lost
// reset clears packet position, pes count and queue; registers go to
// wanted_pid 0 and expect_video 1, written over the apb port at 0 and 4
`default_nettype none
module ts_pid_filter_pes_header_parser_core
    import tspes_pkg::*;
#(
    parameter int PES_COUNT_BITS_P = PES_COUNT_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  ts_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       kind,
    output logic [7:0]       pes_byte,
    output logic [23:0]      byte_index,
    output logic [3:0]       status,
    output logic [32:0]      pts,
    output logic [32:0]      dts,
    output logic [8:0]       payload_begin,
    output logic [23:0]      payload_finish,
    output logic [15:0]      declared_length,
    output logic             last
);

    logic [12:0] pid_reg;
    logic video_reg;
    logic wr_en, accept, ev_push;
    event_t ev;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign prdata = paddr[2] ? {31'd0, video_reg} : {19'd0, pid_reg};
    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pid_reg <= '0;
            video_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            if (paddr[2])
                video_reg <= pwdata[0];
            else
                pid_reg <= pwdata[12:0];
        end
    end

    tspes_front #(
        .PES_COUNT_BITS_P(PES_COUNT_BITS_P)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .ts_byte(ts_byte),
        .wanted_pid(pid_reg),
        .expect_video(video_reg),
        .ev(ev),
        .ev_push(ev_push)
    );

    tspes_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .ev_push(ev_push),
        .ev(ev),
        .q_full(full),
        .pop(pop),
        .empty(empty),
        .kind(kind),
        .pes_byte(pes_byte),
        .byte_index(byte_index),
        .status(status),
        .pts(pts),
        .dts(dts),
        .payload_begin(payload_begin),
        .payload_finish(payload_finish),
        .declared_length(declared_length),
        .last(last)
    );

endmodule
`default_nettype wire

// File: hdl/tspes_front.sv
// packet header checks, pid filter, pes gathering and record judging
`default_nettype none
module tspes_front
    import tspes_pkg::*;
#(
    parameter int PES_COUNT_BITS_P = PES_COUNT_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  ts_byte,
    input  wire logic [12:0] wanted_pid,
    input  wire logic        expect_video,
    output event_t           ev,
    output logic             ev_push
);

    localparam logic [PES_COUNT_BITS_P-1:0] CNT_MAX = '1;

    logic [7:0] pos_reg, pos_next;
    logic pusi_reg, pusi_next, hi_reg, hi_next, match_reg, match_next;
    logic collect_reg, collect_next;
    logic [1:0] afc_reg, afc_next;
    logic [8:0] poff_reg, poff_next;
    logic [3:0] err_reg, err_next;
    logic [PES_COUNT_BITS_P-1:0] cnt_reg, cnt_next, cnt_eff;
    logic [7:0] hdr_reg [HDR_BYTES];
    logic [3:0] judge_st;
    logic [1:0] fl;
    logic [32:0] c33, begin33, len33;
    logic [8:0] hbegin;
    logic [15:0] hlen;
    logic [32:0] pts_w, dts_w;
    logic fwd, hdr_we;
    logic [31:0] cnt32;

    assign fl = hdr_reg[7][7:6];
    assign c33 = 33'(cnt_reg);
    assign hbegin = 9'(hdr_reg[8]) + 9'd9;
    assign begin33 = 33'(hbegin);
    assign hlen = {hdr_reg[4], hdr_reg[5]};
    assign len33 = 33'(hlen) + 33'd6;
    assign pts_w = {hdr_reg[9][3:1], hdr_reg[10], hdr_reg[11][7:1], hdr_reg[12],
                    hdr_reg[13][7:1]};
    assign dts_w = (fl == 2'b11) ? {hdr_reg[14][3:1], hdr_reg[15], hdr_reg[16][7:1],
                    hdr_reg[17], hdr_reg[18][7:1]} : pts_w;

    always_comb
    begin
        judge_st = ST_OK;
        if (c33 < 33'd4)
            judge_st = ST_SHORT;
        else if (expect_video ? (hdr_reg[3][7:4] != 4'he) : (hdr_reg[3] != AUDIO_ID))
            judge_st = ST_STREAM_ID;
        else if (c33 < 33'd9)
            judge_st = ST_SHORT;
        else if (hdr_reg[0] != 8'd0 || hdr_reg[1] != 8'd0 || hdr_reg[2] != 8'd1)
            judge_st = ST_START_CODE;
        else if (begin33 > c33)
            judge_st = ST_HDR_LEN;
        else if (fl == 2'd0)
            judge_st = ST_NO_PTS;
        else if (fl == 2'd1)
            judge_st = ST_BAD_FLAGS;
        else if (fl == 2'd3 && c33 < 33'd19)
            judge_st = ST_SHORT;
        else if (fl == 2'd3 && hdr_reg[14][7:4] != 4'd1)
            judge_st = ST_DTS_PREFIX;
        else if (fl == 2'd3 && (!hdr_reg[14][0] || !hdr_reg[16][0] || !hdr_reg[18][0]))
            judge_st = ST_MARKER;
        else if (c33 < 33'd14)
            judge_st = ST_SHORT;
        else if (hdr_reg[9][7:4] != {2'b00, fl})
            judge_st = ST_PTS_PREFIX;
        else if (!hdr_reg[9][0] || !hdr_reg[11][0] || !hdr_reg[13][0])
            judge_st = ST_MARKER;
        else if (begin33 >= c33)
            judge_st = ST_EMPTY;
        else if (hlen != 16'd0 && len33 > c33)
            judge_st = ST_DECL_LEN;
    end

    always_comb
    begin
        pos_next = (pos_reg == 8'(TS_PACKET_BYTES - 1)) ? 8'd0 : pos_reg + 8'd1;
        pusi_next = pusi_reg;
        hi_next = hi_reg;
        match_next = match_reg;
        collect_next = collect_reg;
        afc_next = afc_reg;
        poff_next = poff_reg;
        err_next = err_reg;
        cnt_eff = cnt_reg;
        ev = '0;
        case (pos_reg)
            8'd0:
            begin
                pusi_next = 1'b0;
                hi_next = 1'b0;
                match_next = 1'b0;
                collect_next = 1'b0;
                afc_next = 2'd0;
                err_next = (ts_byte != SYNC_BYTE) ? ST_SYNC : ST_OK;
            end
            8'd1:
            begin
                pusi_next = ts_byte[6];
                hi_next = (ts_byte[4:0] == wanted_pid[12:8]);
            end
            8'd2:
            begin
                match_next = hi_reg && (ts_byte == wanted_pid[7:0]);
                hi_next = 1'b0;
            end
            8'd3:
            begin
                afc_next = ts_byte[5:4];
                if (err_reg == ST_OK && ts_byte[5:4] == 2'd0)
                    err_next = ST_AFC;
                poff_next = (ts_byte[5:4] == 2'd1) ? 9'd4 : 9'(TS_PACKET_BYTES);
            end
            8'd4:
            begin
                if (afc_reg == 2'd3)
                    poff_next = 9'(ts_byte) + 9'd5;
                if (err_reg == ST_OK && poff_next > 9'(TS_PACKET_BYTES))
                    err_next = ST_OFFSET;
                if (err_next != ST_OK)
                begin
                    ev.has_rec = 1'b1;
                    ev.rec_kind = KIND_TS_ERR;
                    ev.status = err_next;
                    cnt_eff = '0;
                end
                else if (match_reg)
                begin
                    if (pusi_reg)
                    begin
                        if (cnt_reg != '0)
                        begin
                            ev.has_rec = 1'b1;
                            ev.rec_kind = KIND_RECORD;
                            ev.status = judge_st;
                            if (judge_st == ST_OK)
                            begin
                                ev.pts = pts_w;
                                ev.dts = dts_w;
                                ev.payload_begin = hbegin;
                                ev.declared_length = hlen;
                                ev.payload_finish = (hlen != 16'd0) ? 24'(len33)
                                                                    : cnt32[23:0];
                            end
                            cnt_eff = '0;
                        end
                        collect_next = 1'b1;
                    end
                    else if (cnt_reg != '0)
                        collect_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        fwd = (pos_reg >= 8'd4) && collect_next && (9'(pos_reg) >= poff_next);
        ev.has_fwd = fwd;
        ev.pes_byte = ts_byte;
        ev.byte_index = 24'(32'(cnt_eff));
        if (!fwd)
        begin
            ev.pes_byte = '0;
            ev.byte_index = '0;
        end
        hdr_we = fwd && (32'(cnt_eff) < 32'(HDR_BYTES));
        cnt_next = (fwd && cnt_eff != CNT_MAX) ? cnt_eff + 1'b1 : cnt_eff;
        ev_push = accept && (ev.has_rec || fwd);
    end

    assign cnt32 = 32'(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            pusi_reg <= 1'b0;
            hi_reg <= 1'b0;
            match_reg <= 1'b0;
            collect_reg <= 1'b0;
            afc_reg <= '0;
            poff_reg <= 9'd4;
            err_reg <= '0;
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            pusi_reg <= pusi_next;
            hi_reg <= hi_next;
            match_reg <= match_next;
            collect_reg <= collect_next;
            afc_reg <= afc_next;
            poff_reg <= poff_next;
            err_reg <= err_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hdr_we)
            hdr_reg[cnt_eff[4:0]] <= ts_byte;
    end

endmodule
`default_nettype wire

// File: hdl/tspes_back.sv
// event queue and serializer toward the result side
`default_nettype none
module tspes_back
    import tspes_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        ev_push,
    input  event_t           ev,
    output logic             q_full,
    input  wire logic        pop,
    output logic             empty,
    output logic [1:0]       kind,
    output logic [7:0]       pes_byte,
    output logic [23:0]      byte_index,
    output logic [3:0]       status,
    output logic [32:0]      pts,
    output logic [32:0]      dts,
    output logic [8:0]       payload_begin,
    output logic [23:0]      payload_finish,
    output logic [15:0]      declared_length,
    output logic             last
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    event_t q_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [PW:0] cnt_reg;
    logic phase_reg;
    event_t head;
    logic take, deq, rec_phase;

    assign head = q_reg[rd_reg];
    assign empty = (cnt_reg == '0);
    assign q_full = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign take = pop && !empty;
    assign rec_phase = head.has_rec && !phase_reg;
    assign deq = take && !(rec_phase && head.has_fwd);

    always_comb
    begin
        if (rec_phase)
        begin
            kind = head.rec_kind;
            pes_byte = '0;
            byte_index = '0;
            status = head.status;
            pts = head.pts;
            dts = head.dts;
            payload_begin = head.payload_begin;
            payload_finish = head.payload_finish;
            declared_length = head.declared_length;
            last = !head.has_fwd;
        end
        else
        begin
            kind = KIND_BYTE;
            pes_byte = head.pes_byte;
            byte_index = head.byte_index;
            status = ST_OK;
            pts = '0;
            dts = '0;
            payload_begin = '0;
            payload_finish = '0;
            declared_length = '0;
            last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (ev_push)
                wr_reg <= wr_reg + 1'b1;
            if (deq)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(ev_push) - (PW+1)'(deq);
            if (take)
                phase_reg <= !deq;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_push)
            q_reg[wr_reg] <= ev;
    end

endmodule
`default_nettype wire

// File: tb/ts_pid_filter_pes_header_parser_core_tb.sv
// testbench for the transport stream pid filter and pes header parser core
`timescale 1ns / 100ps
module ts_pid_filter_pes_header_parser_core_tb;
    import tspes_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  pes_byte;
        logic [23:0] byte_index;
        logic [3:0]  status;
        logic [32:0] pts;
        logic [32:0] dts;
        logic [8:0]  payload_begin;
        logic [23:0] payload_finish;
        logic [15:0] declared_length;
        logic        last;
    } word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  ts_byte = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  pes_byte;
    logic [23:0] byte_index;
    logic [3:0]  status;
    logic [32:0] pts;
    logic [32:0] dts;
    logic [8:0]  payload_begin;
    logic [23:0] payload_finish;
    logic [15:0] declared_length;
    logic        last;

    logic [7:0] pending_bytes[$];
    word_t      expected_words[$];
    int         error_count = 0;
    int         cyc = 0;
    int         words_seen = 0;
    int         rx_hold = 0;

    // predictor state and register copies
    logic [12:0] cfg_pid = '0;
    logic        cfg_video = 1'b1;
    int          pkt_pos = 0;
    logic        fl_pusi = 0, fl_hi = 0, fl_match = 0, fl_collect = 0;
    logic [1:0]  fl_afc = '0;
    int          pay_off = 4;
    logic [23:0] pes_cnt = '0;
    logic [7:0]  hdr_store[HDR_BYTES];
    logic [3:0]  pkt_err = '0;

    ts_pid_filter_pes_header_parser_core dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .ts_byte(ts_byte),
        .empty(empty), .pop(pop),
        .kind(kind), .pes_byte(pes_byte), .byte_index(byte_index), .status(status),
        .pts(pts), .dts(dts), .payload_begin(payload_begin),
        .payload_finish(payload_finish), .declared_length(declared_length), .last(last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [32:0] time_stamp(input int at);
        time_stamp = {hdr_store[at][3:1], hdr_store[at+1], hdr_store[at+2][7:1],
                      hdr_store[at+3], hdr_store[at+4][7:1]};
    endfunction

    function automatic logic [3:0] judge_pes();
        int c;
        int beg;
        int len;
        logic [1:0] fl;
        c = int'(pes_cnt);
        if (c < 4) return ST_SHORT;
        if (cfg_video) begin
            if (hdr_store[3][7:4] != 4'he) return ST_STREAM_ID;
        end
        else if (hdr_store[3] != AUDIO_ID) return ST_STREAM_ID;
        if (c < 9) return ST_SHORT;
        if (hdr_store[0] != 0 || hdr_store[1] != 0 || hdr_store[2] != 1) return ST_START_CODE;
        beg = int'(hdr_store[8]) + 9;
        if (beg > c) return ST_HDR_LEN;
        fl = hdr_store[7][7:6];
        if (fl == 2'd0) return ST_NO_PTS;
        if (fl == 2'd1) return ST_BAD_FLAGS;
        if (fl == 2'd3) begin
            if (c < 19) return ST_SHORT;
            if (hdr_store[14][7:4] != 4'd1) return ST_DTS_PREFIX;
            if (!hdr_store[14][0] || !hdr_store[16][0] || !hdr_store[18][0]) return ST_MARKER;
        end
        if (c < 14) return ST_SHORT;
        if (hdr_store[9][7:4] != {2'b00, fl}) return ST_PTS_PREFIX;
        if (!hdr_store[9][0] || !hdr_store[11][0] || !hdr_store[13][0]) return ST_MARKER;
        if (beg >= c) return ST_EMPTY;
        len = int'({hdr_store[4], hdr_store[5]});
        if (len != 0 && len + 6 > c) return ST_DECL_LEN;
        return ST_OK;
    endfunction

    task automatic predict_byte(input logic [7:0] b);
        word_t w[2];
        int n;
        logic [1:0] a;
        logic [3:0] st;
        logic [15:0] len;
        n = 0;
        a = fl_afc;
        w[0] = '0;
        w[1] = '0;
        case (pkt_pos)
            0:
            begin
                fl_pusi = 0; fl_hi = 0; fl_match = 0; fl_afc = 0; fl_collect = 0;
                pkt_err = (b != SYNC_BYTE) ? ST_SYNC : ST_OK;
            end
            1:
            begin
                if (b[6]) fl_pusi = 1;
                if (b[4:0] == cfg_pid[12:8]) fl_hi = 1;
            end
            2:
            begin
                if (fl_hi && b == cfg_pid[7:0]) fl_match = 1;
                fl_hi = 0;
            end
            3:
            begin
                a = b[5:4];
                fl_afc = a;
                if (pkt_err == ST_OK && a == 2'd0) pkt_err = ST_AFC;
                pay_off = (a == 2'd1) ? 4 : TS_PACKET_BYTES;
            end
            4:
            begin
                if (a == 2'd3) pay_off = 5 + int'(b);
                if (pkt_err == ST_OK && pay_off > TS_PACKET_BYTES) pkt_err = ST_OFFSET;
                if (pkt_err != ST_OK) begin
                    w[n].kind = KIND_TS_ERR;
                    w[n].status = pkt_err;
                    n++;
                    pes_cnt = '0;
                end
                else if (fl_match) begin
                    if (fl_pusi) begin
                        if (pes_cnt != 0) begin
                            st = judge_pes();
                            w[n].kind = KIND_RECORD;
                            w[n].status = st;
                            if (st == ST_OK) begin
                                len = {hdr_store[4], hdr_store[5]};
                                w[n].pts = time_stamp(9);
                                w[n].dts = (hdr_store[7][7:6] == 2'd3) ? time_stamp(14)
                                                                       : time_stamp(9);
                                w[n].payload_begin = 9'(hdr_store[8]) + 9'd9;
                                w[n].payload_finish = (len != 0) ? 24'(len) + 24'd6 : pes_cnt;
                                w[n].declared_length = len;
                            end
                            n++;
                            pes_cnt = '0;
                        end
                        fl_collect = 1;
                    end
                    else if (pes_cnt != 0) fl_collect = 1;
                end
            end
            default: ;
        endcase
        if (pkt_pos >= 4 && fl_collect && pkt_pos >= pay_off) begin
            w[n].kind = KIND_BYTE;
            w[n].pes_byte = b;
            w[n].byte_index = pes_cnt;
            n++;
            if (pes_cnt < HDR_BYTES) hdr_store[pes_cnt] = b;
            if (pes_cnt != '1) pes_cnt++;
        end
        pkt_pos = (pkt_pos + 1 >= TS_PACKET_BYTES) ? 0 : pkt_pos + 1;
        if (n > 0) w[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) expected_words.push_back(w[i]);
    endtask

    // sender
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (push && !full) begin
                predict_byte(ts_byte);
                void'(pending_bytes.pop_front());
            end
            if (pending_bytes.size() != 0 &&
                !($urandom_range(99) < 13 && !(cyc > 700 && cyc < 1000))) begin
                push <= 1'b1;
                ts_byte <= pending_bytes[0];
            end
            else push <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // receiver
    always @(posedge clk)
    begin
        word_t e;
        if (rst_n) begin
            if (pop && !empty) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual kind %0d",
                             $time, kind);
                    error_count++;
                end
                else begin
                    e = expected_words.pop_front();
                    check_field("kind", e.kind, kind);
                    check_field("pes_byte", e.pes_byte, pes_byte);
                    check_field("byte_index", e.byte_index, byte_index);
                    check_field("status", e.status, status);
                    check_field("pts", e.pts, pts);
                    check_field("dts", e.dts, dts);
                    check_field("payload_begin", e.payload_begin, payload_begin);
                    check_field("payload_finish", e.payload_finish, payload_finish);
                    check_field("declared_length", e.declared_length, declared_length);
                    check_field("last", e.last, last);
                end
                words_seen++;
                if (words_seen == 150) rx_hold = 400;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                pop <= 1'b0;
            end
            else pop <= !($urandom_range(99) < 13 && !(cyc > 700 && cyc < 1000));
        end
    end

    always @(posedge clk)
    begin
        cyc++;
        if (cyc > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic reg_write(input int idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(4 * idx);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == 0) cfg_pid = value[12:0];
        else cfg_video = value[0];
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || push || expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // pes header bytes only; occasionally broken
    task automatic make_pes(ref logic [7:0] hb[$]);
        logic [1:0] fl;
        int hl;
        int r;
        hb.delete();
        r = $urandom_range(99);
        fl = (r < 45) ? 2'd2 : (r < 90) ? 2'd3 : 2'($urandom_range(1));
        hl = (fl == 2'd3) ? 10 : 5;
        if ($urandom_range(9) == 0) hl = $urandom_range(40);
        hb.push_back(8'h00);
        hb.push_back(8'h00);
        hb.push_back(($urandom_range(19) == 0) ? 8'h02 : 8'h01);
        if ($urandom_range(14) == 0) hb.push_back(8'($urandom));
        else hb.push_back(cfg_video ? {4'he, 4'($urandom)} : AUDIO_ID);
        r = $urandom_range(3);
        hb.push_back(r == 0 ? 8'($urandom_range(1)) : 8'h00);
        hb.push_back(r == 0 ? 8'($urandom_range(255)) : 8'h00);
        hb.push_back(8'h80);
        hb.push_back({fl, 6'($urandom)});
        hb.push_back(8'(hl));
        hb.push_back({2'b00, fl, 3'($urandom), ($urandom_range(19) != 0)});
        hb.push_back(8'($urandom));
        hb.push_back({7'($urandom), ($urandom_range(19) != 0)});
        hb.push_back(8'($urandom));
        hb.push_back({7'($urandom), ($urandom_range(19) != 0)});
        hb.push_back({($urandom_range(19) == 0) ? 4'($urandom) : 4'd1, 3'($urandom),
                      ($urandom_range(19) != 0)});
        hb.push_back(8'($urandom));
        hb.push_back({7'($urandom), ($urandom_range(19) != 0)});
        hb.push_back(8'($urandom));
        hb.push_back({7'($urandom), ($urandom_range(19) != 0)});
    endtask

    task automatic add_packet(input logic [12:0] pid, input logic pusi, input logic [1:0] afc,
                              input int alen, input logic bad_sync);
        logic [7:0] hb[$];
        int j;
        if (pusi) make_pes(hb);
        pending_bytes.push_back(bad_sync ? (8'($urandom) | 8'h80) : SYNC_BYTE);
        pending_bytes.push_back({1'($urandom), pusi, 1'($urandom), pid[12:8]});
        pending_bytes.push_back(pid[7:0]);
        pending_bytes.push_back({2'($urandom), afc, 4'($urandom)});
        j = 0;
        for (int p = 4; p < TS_PACKET_BYTES; p++) begin
            if (afc == 2'd3 && p == 4) pending_bytes.push_back(8'(alen));
            else if ((afc == 2'd1 || (afc == 2'd3 && p >= 5 + alen)) && j < hb.size()) begin
                pending_bytes.push_back(hb[j]);
                j++;
            end
            else pending_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic random_packets(input int count);
        int r;
        logic [12:0] pid;
        logic [1:0] afc;
        for (int k = 0; k < count; k++) begin
            pid = ($urandom_range(3) != 0) ? cfg_pid : 13'($urandom);
            r = $urandom_range(99);
            afc = (r < 45) ? 2'd1 : (r < 92) ? 2'd3 : (r < 96) ? 2'd2 : 2'd0;
            r = ($urandom_range(3) == 0) ? $urandom_range(184) : $urandom_range(150, 183);
            add_packet(pid, $urandom_range(99) < 45, afc, r, $urandom_range(29) == 0);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        reg_write(0, 32'd0);
        reg_write(1, 32'd1);
        // pes start, continuation, then a unit start closes it
        add_packet(13'd0, 1'b1, 2'd1, 0, 1'b0);
        add_packet(13'd0, 1'b0, 2'd3, 170, 1'b0);
        add_packet(13'd0, 1'b1, 2'd3, 160, 1'b0);
        // reserved adaptation control drops the pending pes
        add_packet(13'd0, 1'b0, 2'd0, 0, 1'b0);
        wait_idle();
        reg_write(0, 32'h1fff);
        reg_write(1, 32'd0);
        random_packets(1);
        wait_idle();
        if (error_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
